[sv/erv_pkg.sv]
// ----------------------------------------------------------------------------
// erv_pkg
// shared constants, types and the arctangent table for the euler rotator
// ----------------------------------------------------------------------------
`default_nettype none

package erv_pkg;

    localparam int COMP_WIDTH_DEF  = 32;
    localparam int ANGLE_WIDTH_DEF = 16;
    localparam int CORDIC_STEPS    = 24;
    localparam int CS_W            = 34;
    localparam int TRIG_W          = 32;
    localparam int LANES           = 3;

    localparam logic signed [CS_W-1:0] CORDIC_GAIN_Q30 = 34'sd652032874;
    localparam logic signed [CS_W-1:0] QUARTER_TURN    = 34'sh0_4000_0000;
    localparam logic signed [CS_W-1:0] HALF_TURN       = 34'sh0_8000_0000;

    // lane order: y angle, x angle, z angle
    localparam int LANE_Y = 0;
    localparam int LANE_X = 1;
    localparam int LANE_Z = 2;

    typedef struct packed {
        logic signed [CS_W-1:0] a;
        logic signed [CS_W-1:0] x;
        logic signed [CS_W-1:0] y;
        logic                   flip;
    } cordic_lane_t;

    function automatic logic signed [CS_W-1:0] atan_q(input int step);
        logic signed [CS_W-1:0] r;
        case (step)
            0:       r = 34'sd536870912;
            1:       r = 34'sd316933406;
            2:       r = 34'sd167458907;
            3:       r = 34'sd85004756;
            4:       r = 34'sd42667331;
            5:       r = 34'sd21354465;
            6:       r = 34'sd10679838;
            7:       r = 34'sd5340245;
            8:       r = 34'sd2670163;
            9:       r = 34'sd1335087;
            10:      r = 34'sd667544;
            11:      r = 34'sd333772;
            12:      r = 34'sd166886;
            13:      r = 34'sd83443;
            14:      r = 34'sd41722;
            15:      r = 34'sd20861;
            16:      r = 34'sd10430;
            17:      r = 34'sd5215;
            18:      r = 34'sd2608;
            19:      r = 34'sd1304;
            20:      r = 34'sd652;
            21:      r = 34'sd326;
            22:      r = 34'sd163;
            23:      r = 34'sd81;
            default: r = '0;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

[sv/erv_cordic_cell.sv]
// ----------------------------------------------------------------------------
// erv_cordic_cell
// one cordic micro-rotation for all three angles, vector carried alongside
// ----------------------------------------------------------------------------
`default_nettype none

module erv_cordic_cell
    import erv_pkg::*;
#(
    parameter int STEP = 0,
    parameter int CW   = COMP_WIDTH_DEF
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  step_en,
    input  wire logic                  valid_in,
    input  wire cordic_lane_t [LANES-1:0] lane_in,
    input  wire logic [CW-1:0]         vx_in,
    input  wire logic [CW-1:0]         vy_in,
    input  wire logic [CW-1:0]         vz_in,
    output logic                       valid_out,
    output cordic_lane_t [LANES-1:0]   lane_out,
    output logic [CW-1:0]              vx_out,
    output logic [CW-1:0]              vy_out,
    output logic [CW-1:0]              vz_out
);

    logic                     valid_reg;
    cordic_lane_t [LANES-1:0] lane_reg;
    cordic_lane_t [LANES-1:0] lane_next;
    logic [CW-1:0]            vx_reg;
    logic [CW-1:0]            vy_reg;
    logic [CW-1:0]            vz_reg;

    always_comb
    begin
        for (int k = 0; k < LANES; k++)
        begin
            lane_next[k].flip = lane_in[k].flip;
            if (lane_in[k].a >= 0)
            begin
                lane_next[k].x = lane_in[k].x - (lane_in[k].y >>> STEP);
                lane_next[k].y = lane_in[k].y + (lane_in[k].x >>> STEP);
                lane_next[k].a = lane_in[k].a - atan_q(STEP);
            end
            else
            begin
                lane_next[k].x = lane_in[k].x + (lane_in[k].y >>> STEP);
                lane_next[k].y = lane_in[k].y - (lane_in[k].x >>> STEP);
                lane_next[k].a = lane_in[k].a + atan_q(STEP);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (step_en)
        begin
            valid_reg <= valid_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step_en)
        begin
            lane_reg <= lane_next;
            vx_reg   <= vx_in;
            vy_reg   <= vy_in;
            vz_reg   <= vz_in;
        end
    end

    assign valid_out = valid_reg;
    assign lane_out  = lane_reg;
    assign vx_out    = vx_reg;
    assign vy_out    = vy_reg;
    assign vz_out    = vz_reg;

endmodule

`default_nettype wire

[sv/erv_plane.sv]
// ----------------------------------------------------------------------------
// erv_plane
// two-stage plane rotation: r0 = a*c - b*s, r1 = a*s + b*c, rounded q30
// ----------------------------------------------------------------------------
`default_nettype none

module erv_plane
    import erv_pkg::*;
#(
    parameter int WW = COMP_WIDTH_DEF + 3,
    parameter int SW = COMP_WIDTH_DEF + 3
)
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     step_en,
    input  wire logic                     valid_in,
    input  wire logic signed [WW-1:0]     a,
    input  wire logic signed [WW-1:0]     b,
    input  wire logic signed [TRIG_W-1:0] c,
    input  wire logic signed [TRIG_W-1:0] s,
    input  wire logic [SW-1:0]            side_in,
    output logic                          valid_out,
    output logic signed [WW-1:0]          r0,
    output logic signed [WW-1:0]          r1,
    output logic [SW-1:0]                 side_out
);

    localparam int LO  = (WW + 1) / 2;
    localparam int HI  = WW - LO;
    localparam int LPW = LO + 1 + TRIG_W;
    localparam int HPW = HI + TRIG_W;
    localparam int PW  = WW + TRIG_W + 2;

    localparam logic signed [PW-1:0] ROUND_HALF = PW'(64'sd536870912);

    logic signed [LO:0]    a_lo;
    logic signed [LO:0]    b_lo;
    logic signed [HI-1:0]  a_hi;
    logic signed [HI-1:0]  b_hi;

    // partial products, registered
    logic signed [LPW-1:0] alc_reg, als_reg, blc_reg, bls_reg;
    logic signed [HPW-1:0] ahc_reg, ahs_reg, bhc_reg, bhs_reg;
    logic [SW-1:0]         side1_reg;
    logic                  valid1_reg;

    logic signed [PW-1:0]  sum0;
    logic signed [PW-1:0]  sum1;

    logic signed [WW-1:0]  r0_reg, r1_reg;
    logic [SW-1:0]         side2_reg;
    logic                  valid2_reg;

    assign a_lo = $signed({1'b0, a[LO-1:0]});
    assign b_lo = $signed({1'b0, b[LO-1:0]});
    assign a_hi = a[WW-1:LO];
    assign b_hi = b[WW-1:LO];

    always_comb
    begin
        sum0 = (PW'(ahc_reg) <<< LO) + PW'(alc_reg)
             - (PW'(bhs_reg) <<< LO) - PW'(bls_reg) + ROUND_HALF;
        sum1 = (PW'(ahs_reg) <<< LO) + PW'(als_reg)
             + (PW'(bhc_reg) <<< LO) + PW'(blc_reg) + ROUND_HALF;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid1_reg <= 1'b0;
            valid2_reg <= 1'b0;
        end
        else if (step_en)
        begin
            valid1_reg <= valid_in;
            valid2_reg <= valid1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step_en)
        begin
            alc_reg   <= a_lo * c;
            als_reg   <= a_lo * s;
            blc_reg   <= b_lo * c;
            bls_reg   <= b_lo * s;
            ahc_reg   <= a_hi * c;
            ahs_reg   <= a_hi * s;
            bhc_reg   <= b_hi * c;
            bhs_reg   <= b_hi * s;
            side1_reg <= side_in;
            r0_reg    <= sum0[WW+29:30];
            r1_reg    <= sum1[WW+29:30];
            side2_reg <= side1_reg;
        end
    end

    assign valid_out = valid2_reg;
    assign r0        = r0_reg;
    assign r1        = r1_reg;
    assign side_out  = side2_reg;

endmodule

`default_nettype wire

[sv/euler_rotate_vector_3d_core.sv]
// ----------------------------------------------------------------------------
// euler_rotate_vector_3d_core
// rotates a q16.16 vector about y, then x, then z by three binary angles
// ----------------------------------------------------------------------------
// input channel in_valid/in_ready carries the vector and the three angles;
// output channel out_valid/out_ready carries the rotated, saturated vector.
// one request is taken and one result leaves per clock while the chain moves.
// the pipeline is 24 cordic cells that compute all three sine/cosine pairs
// side by side, three plane rotations that each register partial products
// and then the sum and rounding, and the output register.
// the whole chain advances together; it moves whenever the last plane stage
// is empty or the output register is free or being taken, so a stalled
// receiver holds the output and back-pressure reaches in_ready only once the
// result behind it is also waiting. reset empties every stage; no request
// is in flight after it and in_ready is high.
// ----------------------------------------------------------------------------
`default_nettype none

module euler_rotate_vector_3d_core
    import erv_pkg::*;
#(
    parameter int COMP_WIDTH  = COMP_WIDTH_DEF,
    parameter int ANGLE_WIDTH = ANGLE_WIDTH_DEF
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   in_valid,
    output logic                        in_ready,
    input  wire logic [COMP_WIDTH-1:0]  in_x,
    input  wire logic [COMP_WIDTH-1:0]  in_y,
    input  wire logic [COMP_WIDTH-1:0]  in_z,
    input  wire logic [ANGLE_WIDTH-1:0] angle_x,
    input  wire logic [ANGLE_WIDTH-1:0] angle_y,
    input  wire logic [ANGLE_WIDTH-1:0] angle_z,
    output logic                        out_valid,
    input  wire logic                   out_ready,
    output logic [COMP_WIDTH-1:0]       out_x,
    output logic [COMP_WIDTH-1:0]       out_y,
    output logic [COMP_WIDTH-1:0]       out_z
);

    localparam int CW   = COMP_WIDTH;
    localparam int WW   = COMP_WIDTH + 3;
    localparam int SW_Y = WW + 4 * TRIG_W;
    localparam int SW_X = WW + 2 * TRIG_W;

    logic step_en;

    logic [ANGLE_WIDTH-1:0]   ang [LANES];
    cordic_lane_t [LANES-1:0] lane_c [CORDIC_STEPS+1];
    logic [CW-1:0]            vx_c [CORDIC_STEPS+1];
    logic [CW-1:0]            vy_c [CORDIC_STEPS+1];
    logic [CW-1:0]            vz_c [CORDIC_STEPS+1];
    logic                     valid_c [CORDIC_STEPS+1];

    logic signed [CS_W-1:0]   wide_ang [LANES];
    logic signed [CS_W-1:0]   cx_full [LANES];
    logic signed [CS_W-1:0]   sx_full [LANES];
    logic signed [TRIG_W-1:0] cos_v [LANES];
    logic signed [TRIG_W-1:0] sin_v [LANES];
    logic signed [TRIG_W-1:0] neg_sin_y;

    logic                  valid_py, valid_px, valid_pz;
    logic signed [WW-1:0]  py_r0, py_r1, px_r0, px_r1, pz_r0, pz_r1;
    logic [SW_Y-1:0]       side_py_in, side_py_out;
    logic [SW_X-1:0]       side_px_in, side_px_out;
    logic [WW-1:0]         side_pz_in, side_pz_out;

    logic                  out_valid_reg;
    logic [CW-1:0]         out_x_reg, out_y_reg, out_z_reg;

    function automatic logic [COMP_WIDTH-1:0] sat_comp(input logic signed [WW-1:0] v);
        logic [COMP_WIDTH-1:0] r;
        if ((&v[WW-1:CW-1]) || !(|v[WW-1:CW-1]))
        begin
            r = v[CW-1:0];
        end
        else if (v[WW-1])
        begin
            r = {1'b1, {(CW-1){1'b0}}};
        end
        else
        begin
            r = {1'b0, {(CW-1){1'b1}}};
        end
        return r;
    endfunction

    // chain moves unless a finished result is blocked behind a stalled output
    assign step_en  = !valid_pz || !out_valid_reg || out_ready;
    assign in_ready = step_en;

    assign ang[LANE_Y] = angle_y;
    assign ang[LANE_X] = angle_x;
    assign ang[LANE_Z] = angle_z;

    // widen to a 32-bit turn and fold into +-pi/2
    always_comb
    begin
        for (int k = 0; k < LANES; k++)
        begin
            wide_ang[k] = $signed({{(CS_W-ANGLE_WIDTH){ang[k][ANGLE_WIDTH-1]}}, ang[k]})
                          <<< (32 - ANGLE_WIDTH);
            lane_c[0][k].x = CORDIC_GAIN_Q30;
            lane_c[0][k].y = '0;
            if (wide_ang[k] > QUARTER_TURN)
            begin
                lane_c[0][k].a    = wide_ang[k] - HALF_TURN;
                lane_c[0][k].flip = 1'b1;
            end
            else if (wide_ang[k] < -QUARTER_TURN)
            begin
                lane_c[0][k].a    = wide_ang[k] + HALF_TURN;
                lane_c[0][k].flip = 1'b1;
            end
            else
            begin
                lane_c[0][k].a    = wide_ang[k];
                lane_c[0][k].flip = 1'b0;
            end
        end
    end

    assign vx_c[0]    = in_x;
    assign vy_c[0]    = in_y;
    assign vz_c[0]    = in_z;
    assign valid_c[0] = in_valid;

    for (genvar i = 0; i < CORDIC_STEPS; i++)
    begin : g_cordic
        erv_cordic_cell #(
            .STEP (i),
            .CW   (CW)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .step_en   (step_en),
            .valid_in  (valid_c[i]),
            .lane_in   (lane_c[i]),
            .vx_in     (vx_c[i]),
            .vy_in     (vy_c[i]),
            .vz_in     (vz_c[i]),
            .valid_out (valid_c[i+1]),
            .lane_out  (lane_c[i+1]),
            .vx_out    (vx_c[i+1]),
            .vy_out    (vy_c[i+1]),
            .vz_out    (vz_c[i+1])
        );
    end

    // undo the half-turn fold
    always_comb
    begin
        for (int k = 0; k < LANES; k++)
        begin
            cx_full[k] = lane_c[CORDIC_STEPS][k].flip ? -lane_c[CORDIC_STEPS][k].x
                                                      :  lane_c[CORDIC_STEPS][k].x;
            sx_full[k] = lane_c[CORDIC_STEPS][k].flip ? -lane_c[CORDIC_STEPS][k].y
                                                      :  lane_c[CORDIC_STEPS][k].y;
            cos_v[k]   = cx_full[k][TRIG_W-1:0];
            sin_v[k]   = sx_full[k][TRIG_W-1:0];
        end
    end

    assign neg_sin_y  = -sin_v[LANE_Y];
    assign side_py_in = {WW'($signed(vy_c[CORDIC_STEPS])),
                         cos_v[LANE_X], sin_v[LANE_X], cos_v[LANE_Z], sin_v[LANE_Z]};

    // rotation about y
    erv_plane #(
        .WW (WW),
        .SW (SW_Y)
    ) u_plane_y (
        .clk       (clk),
        .rst_n     (rst_n),
        .step_en   (step_en),
        .valid_in  (valid_c[CORDIC_STEPS]),
        .a         (WW'($signed(vx_c[CORDIC_STEPS]))),
        .b         (WW'($signed(vz_c[CORDIC_STEPS]))),
        .c         (cos_v[LANE_Y]),
        .s         (neg_sin_y),
        .side_in   (side_py_in),
        .valid_out (valid_py),
        .r0        (py_r0),
        .r1        (py_r1),
        .side_out  (side_py_out)
    );

    assign side_px_in = {py_r0, side_py_out[2*TRIG_W-1:0]};

    // rotation about x
    erv_plane #(
        .WW (WW),
        .SW (SW_X)
    ) u_plane_x (
        .clk       (clk),
        .rst_n     (rst_n),
        .step_en   (step_en),
        .valid_in  (valid_py),
        .a         ($signed(side_py_out[SW_Y-1:4*TRIG_W])),
        .b         (py_r1),
        .c         ($signed(side_py_out[4*TRIG_W-1:3*TRIG_W])),
        .s         ($signed(side_py_out[3*TRIG_W-1:2*TRIG_W])),
        .side_in   (side_px_in),
        .valid_out (valid_px),
        .r0        (px_r0),
        .r1        (px_r1),
        .side_out  (side_px_out)
    );

    assign side_pz_in = px_r1;

    // rotation about z
    erv_plane #(
        .WW (WW),
        .SW (WW)
    ) u_plane_z (
        .clk       (clk),
        .rst_n     (rst_n),
        .step_en   (step_en),
        .valid_in  (valid_px),
        .a         ($signed(side_px_out[SW_X-1:2*TRIG_W])),
        .b         (px_r0),
        .c         ($signed(side_px_out[2*TRIG_W-1:TRIG_W])),
        .s         ($signed(side_px_out[TRIG_W-1:0])),
        .side_in   (side_pz_in),
        .valid_out (valid_pz),
        .r0        (pz_r0),
        .r1        (pz_r1),
        .side_out  (side_pz_out)
    );

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (valid_pz && step_en)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (valid_pz && step_en)
        begin
            out_x_reg <= sat_comp(pz_r0);
            out_y_reg <= sat_comp(pz_r1);
            out_z_reg <= sat_comp($signed(side_pz_out));
        end
    end

    assign out_valid = out_valid_reg;
    assign out_x     = out_x_reg;
    assign out_y     = out_y_reg;
    assign out_z     = out_z_reg;

`ifndef NO_ASSERTIONS
    a_stall_only_when_blocked: assert property (@(posedge clk) disable iff (!rst_n)
        !step_en |-> (valid_pz && out_valid_reg && !out_ready))
        else $error("chain stalled without a blocked result");

    a_hold_last_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !step_en |=> (valid_pz && $stable(pz_r0) && $stable(pz_r1)))
        else $error("last plane stage changed during stall");

    a_result_lands: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_pz && step_en) |=> out_valid)
        else $error("finished result not loaded into output register");
`endif

endmodule

`default_nettype wire

[verif/euler_rotate_vector_3d_core_test.sv]
// ----------------------------------------------------------------------------
// euler_rotate_vector_3d_core_test
// self-checking bench for the y-x-z euler vector rotator: directed corner
// requests, then random vectors and angles, each result compared field by
// field against a bit-exact cordic and fixed-point rotation predictor
// ----------------------------------------------------------------------------
`default_nettype none

module euler_rotate_vector_3d_core_test
    import erv_pkg::*;
();

    localparam int CW = COMP_WIDTH_DEF;
    localparam int AW = ANGLE_WIDTH_DEF;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int DRAIN_CYCLES = 80;

    typedef struct packed {
        logic [CW-1:0] x;
        logic [CW-1:0] y;
        logic [CW-1:0] z;
    } vec_t;

    logic          clk;
    logic          rst_n;
    logic          in_valid;
    logic          in_ready;
    logic [CW-1:0] in_x;
    logic [CW-1:0] in_y;
    logic [CW-1:0] in_z;
    logic [AW-1:0] angle_x;
    logic [AW-1:0] angle_y;
    logic [AW-1:0] angle_z;
    logic          out_valid;
    logic          out_ready;
    logic [CW-1:0] out_x;
    logic [CW-1:0] out_y;
    logic [CW-1:0] out_z;

    vec_t rotated_q[$];
    int   failures;
    int   requests_sent;
    int   results_seen;
    int   idle_cycles;
    bit   sender_busy_free;
    bit   receiver_busy_free;
    int   hold_off_cycles;

    euler_rotate_vector_3d_core DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_x      (in_x),
        .in_y      (in_y),
        .in_z      (in_z),
        .angle_x   (angle_x),
        .angle_y   (angle_y),
        .angle_z   (angle_z),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_x     (out_x),
        .out_y     (out_y),
        .out_z     (out_z)
    );

    always
    begin
        clk = 1'b1;
        #10;
        clk = 1'b0;
        #10;
    end

    // sine and cosine in q1.30 from a 24-step rotation-mode cordic
    task automatic cordic_sincos(input logic [AW-1:0] ang, output longint s,
                                 output longint c);
        longint a;
        longint cx;
        longint cy;
        longint nx;
        bit     flip;
        a = longint'($signed(ang)) * (longint'(1) << (32 - AW));
        cx = longint'(CORDIC_GAIN_Q30);
        cy = 0;
        flip = 1'b0;
        if (a > (longint'(1) << 30))
        begin
            a -= longint'(1) << 31;
            flip = 1'b1;
        end
        else if (a < -(longint'(1) << 30))
        begin
            a += longint'(1) << 31;
            flip = 1'b1;
        end
        for (int i = 0; i < CORDIC_STEPS; i++)
        begin
            if (a >= 0)
            begin
                nx = cx - (cy >>> i);
                cy = cy + (cx >>> i);
                a -= longint'(atan_q(i));
            end
            else
            begin
                nx = cx + (cy >>> i);
                cy = cy - (cx >>> i);
                a += longint'(atan_q(i));
            end
            cx = nx;
        end
        c = flip ? -cx : cx;
        s = flip ? -cy : cy;
    endtask

    // a*p + b*q rounded half up from q30, exact in 128 bits
    function automatic longint plane_mix(longint a, longint p, longint b, longint q);
        logic signed [127:0] acc;
        acc = 128'(signed'(a)) * 128'(signed'(p)) + 128'(signed'(b)) * 128'(signed'(q))
              + (128'sd1 <<< 29);
        return longint'(acc >>> 30);
    endfunction

    function automatic logic [CW-1:0] clamp_comp(longint v);
        longint hi;
        longint lo;
        hi = (longint'(1) << (CW - 1)) - 1;
        lo = -(longint'(1) << (CW - 1));
        if (v > hi)
            v = hi;
        if (v < lo)
            v = lo;
        return v[CW-1:0];
    endfunction

    task automatic rotate_yxz(input logic [CW-1:0] vx, input logic [CW-1:0] vy,
                              input logic [CW-1:0] vz, input logic [AW-1:0] ax,
                              input logic [AW-1:0] ay, input logic [AW-1:0] az,
                              output vec_t r);
        longint x;
        longint y;
        longint z;
        longint s;
        longint c;
        longint nx;
        longint ny;
        longint nz;
        x = longint'($signed(vx));
        y = longint'($signed(vy));
        z = longint'($signed(vz));
        cordic_sincos(ay, s, c);
        nx = plane_mix(x, c, z, s);
        nz = plane_mix(x, -s, z, c);
        x = nx;
        z = nz;
        cordic_sincos(ax, s, c);
        ny = plane_mix(y, c, z, -s);
        nz = plane_mix(y, s, z, c);
        y = ny;
        z = nz;
        cordic_sincos(az, s, c);
        nx = plane_mix(x, c, y, -s);
        ny = plane_mix(x, s, y, c);
        r.x = clamp_comp(nx);
        r.y = clamp_comp(ny);
        r.z = clamp_comp(z);
    endtask

    task automatic send_request(input logic [CW-1:0] vx, input logic [CW-1:0] vy,
                                input logic [CW-1:0] vz, input logic [AW-1:0] ax,
                                input logic [AW-1:0] ay, input logic [AW-1:0] az);
        vec_t r;
        while (!sender_busy_free && $urandom_range(99) < 31)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        rotate_yxz(vx, vy, vz, ax, ay, az, r);
        in_valid <= 1'b1;
        in_x <= vx;
        in_y <= vy;
        in_z <= vz;
        angle_x <= ax;
        angle_y <= ay;
        angle_z <= az;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        rotated_q.push_back(r);
        requests_sent++;
        @(negedge clk);
    endtask

    function automatic logic [CW-1:0] rand_comp();
        case ($urandom_range(5))
            0: return {1'b0, {(CW-1){1'b1}}};
            1: return {1'b1, {(CW-1){1'b0}}};
            2: return CW'($signed($urandom_range(2000000)) - 1000000);
            3: return CW'($signed($urandom_range(200000000)) - 100000000);
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [AW-1:0] rand_angle();
        case ($urandom_range(7))
            0: return {1'b1, {(AW-1){1'b0}}};
            1: return '0;
            2: return AW'(16'h4000 + $urandom_range(4) - 2);
            3: return AW'(16'hc000 + $urandom_range(4) - 2);
            default: return AW'($urandom);
        endcase
    endfunction

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (rotated_q.size() != 0)
            @(negedge clk);
    endtask

    task automatic test_corners();
        logic [CW-1:0] maxc;
        logic [CW-1:0] minc;
        logic [AW-1:0] pi_n;
        maxc = {1'b0, {(CW-1){1'b1}}};
        minc = {1'b1, {(CW-1){1'b0}}};
        pi_n = {1'b1, {(AW-1){1'b0}}};
        send_request(32'h0001_0000, 32'h0002_0000, 32'h0003_0000, '0, '0, '0);
        send_request(32'h0001_0000, 32'h0002_0000, 32'h0003_0000, pi_n, '0, '0);
        send_request(32'h0001_0000, 32'h0002_0000, 32'h0003_0000, '0, pi_n, '0);
        send_request(32'h0001_0000, 32'h0002_0000, 32'h0003_0000, '0, '0, pi_n);
        send_request(maxc, maxc, maxc, 16'h2000, 16'h2000, 16'h2000);
        send_request(minc, minc, minc, 16'h2000, 16'he000, 16'h2000);
        send_request(maxc, minc, maxc, 16'h7fff, 16'h7fff, 16'h7fff);
        send_request(minc, maxc, minc, pi_n, pi_n, pi_n);
        send_request(maxc, maxc, '0, '0, '0, 16'h2000);
        send_request('1, '1, '1, 16'hffff, 16'hffff, 16'hffff);
        send_request('0, '0, '0, 16'h1234, 16'h5678, 16'h9abc);
        send_request(32'h0001_0000, '0, '0, 16'h4000, 16'h4000, 16'h4000);
        send_request(32'h0001_0000, '0, '0, 16'hc000, 16'hc000, 16'hc000);
        send_request(32'h0001_0000, '0, '0, 16'h4001, 16'h3fff, 16'hc001);
        send_request(32'h5555_5555, 32'haaaa_aaaa, 32'h5555_5555,
                     16'h5555, 16'haaaa, 16'h5555);
        send_request(32'haaaa_aaaa, 32'h5555_5555, 32'haaaa_aaaa,
                     16'haaaa, 16'h5555, 16'haaaa);
        send_request(32'h0000_0001, 32'hffff_ffff, 32'h0000_0001, 16'h0001, 16'h0001, 16'h0001);
    endtask

    task automatic test_random(input int count);
        for (int i = 0; i < count; i++)
            send_request(rand_comp(), rand_comp(), rand_comp(),
                         rand_angle(), rand_angle(), rand_angle());
    endtask

    task automatic test_back_pressure();
        hold_off_cycles = 300;
        sender_busy_free = 1'b1;
        test_random(100);
        sender_busy_free = 1'b0;
    endtask

    task automatic test_no_idling();
        sender_busy_free = 1'b1;
        receiver_busy_free = 1'b1;
        test_random(300);
        sender_busy_free = 1'b0;
        receiver_busy_free = 1'b0;
    endtask

    // receiver: random stalls, plus a long hold-off on request
    always @(negedge clk)
    begin
        if (hold_off_cycles > 0)
        begin
            out_ready <= 1'b0;
            hold_off_cycles <= hold_off_cycles - 1;
        end
        else
            out_ready <= rst_n && (receiver_busy_free || $urandom_range(99) >= 31);
    end

    always @(posedge clk)
    begin
        vec_t e;
        if (rst_n && out_valid && out_ready)
        begin
            results_seen++;
            if (rotated_q.size() == 0)
            begin
                $error("unexpected result x=%h y=%h z=%h", out_x, out_y, out_z);
                failures++;
            end
            else
            begin
                e = rotated_q.pop_front();
                if (out_x !== e.x)
                begin
                    $error("out_x expected %h actual %h", e.x, out_x);
                    failures++;
                end
                if (out_y !== e.y)
                begin
                    $error("out_y expected %h actual %h", e.y, out_y);
                    failures++;
                end
                if (out_z !== e.z)
                begin
                    $error("out_z expected %h actual %h", e.z, out_z);
                    failures++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || !rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("watchdog expired with %0d results outstanding", rotated_q.size());
            $display("euler_rotate_vector_3d_core_test: FAIL");
            $finish;
        end
    end

    initial
    begin
        failures = 0;
        requests_sent = 0;
        results_seen = 0;
        idle_cycles = 0;
        sender_busy_free = 1'b0;
        receiver_busy_free = 1'b0;
        hold_off_cycles = 0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        out_ready = 1'b0;
        in_x = '0;
        in_y = '0;
        in_z = '0;
        angle_x = '0;
        angle_y = '0;
        angle_z = '0;
        repeat (10)
            @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);
        test_corners();
        wait_drained();
        test_random(450);
        test_back_pressure();
        test_no_idling();
        wait_drained();
        test_random(480);
        wait_drained();
        repeat (DRAIN_CYCLES)
            @(negedge clk);
        $display("%0d requests rotated, %0d results checked, including corner vectors,",
                 requests_sent, results_seen);
        $display("half-turn and quarter-turn angles, saturation and receiver hold-off");
        if (failures == 0)
            $display("euler_rotate_vector_3d_core_test: PASS");
        else
            $display("euler_rotate_vector_3d_core_test: FAIL");
        $finish;
    end

endmodule

`default_nettype wire

[filelist.f]
sv/erv_pkg.sv
sv/erv_cordic_cell.sv
sv/erv_plane.sv
sv/euler_rotate_vector_3d_core.sv
verif/euler_rotate_vector_3d_core_test.sv
